// File: hdl/scaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaf_pkg
// Shared types and constants of the stereo comb and allpass filter.
// ----------------------------------------------------------------------------
package scaf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 18;
    localparam int GAIN_FRAC   = 16;
    localparam int LEN_BITS    = 12;
    localparam int LINE_DEPTH  = 4096;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_GAIN   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_GAIN  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_LENGTH = 2'd3;

    localparam logic signed [GAIN_BITS-1:0] OUTPUT_GAIN_RESET = 18'sd65536;

    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_FEEDFWD  = 2'd1,
        MODE_FEEDBACK = 2'd2,
        MODE_ALLPASS  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_GAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_a;
        logic signed [SAMPLE_BITS-1:0] sample_b;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] result_a;
        logic signed [SAMPLE_BITS-1:0] result_b;
    } t_out_word;

endpackage

// File: hdl/scaf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaf_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module scaf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/stereo_comb_allpass_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_comb_allpass_filter
// Stereo comb, feedback comb and allpass section over a shared delay RAM.
// ----------------------------------------------------------------------------
// Input words arrive on i_valid/o_ready as one stereo pair, and result words
// leave on o_valid/i_ready. Configuration is to be written through i_cfg_we,
// i_cfg_addr and i_cfg_wdata only while no word is in flight; the block
// does not enforce this. One word is processed at a time. The delay tap is
// read from the line RAM on acceptance, the gain products are registered,
// and the sums, saturation and write-back happen in the following cycle.
// After acceptance the word passes through ST_READ and ST_SUM, then ST_GAIN
// in feedback mode, where the output gain multiplies the stored value, and
// the result is loaded in ST_DONE. A new word is accepted the cycle after
// the result is loaded. The output register holds one result; when the
// receiver stalls, the next word is still accepted and processed, and then
// waits until the register frees up. Reset sets the state, output-valid,
// write-position, wrap-flag and configuration registers to their defaults
// and empties the delay line logically: entries not written since reset read
// as zero, tracked by the write position and a wrap flag, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_filter #(
    parameter int LINE_DEPTH = scaf_pkg::LINE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  scaf_pkg::t_in_word                   i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output scaf_pkg::t_out_word                  o_data,
    input  logic                                 i_cfg_we,
    input  logic [scaf_pkg::CFG_IDX_BITS-1:0]    i_cfg_addr,
    input  logic [scaf_pkg::GAIN_BITS-1:0]       i_cfg_wdata
);

    import scaf_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + GAIN_BITS;
    localparam int TW = PW - GAIN_FRAC;
    localparam int SW = TW + 1;
    localparam int NCH = 2;

    function automatic logic [AW-1:0] f_len_mod(input logic [LEN_BITS-1:0] len);
        logic [31:0] rem;
        rem = 32'(len);
        for (int k = 7; k >= 0; k--) begin
            if (rem >= (32'(LINE_DEPTH) << k)) begin
                rem = rem - (32'(LINE_DEPTH) << k);
            end
        end
        return AW'(rem);
    endfunction

    function automatic logic signed [TW-1:0] f_trunc(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] bias;
        logic signed [PW-1:0] q;
        bias = p[PW-1] ? PW'((1 << GAIN_FRAC) - 1) : '0;
        q = p + bias;
        return TW'(q >>> GAIN_FRAC);
    endfunction

    function automatic logic signed [SB-1:0] f_sat(input logic signed [SW-1:0] v);
        logic [SW-SB:0] top;
        top = v[SW-1:SB-1];
        if (top == '0 || top == '1) begin
            return v[SB-1:0];
        end
        return v[SW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    endfunction

    t_state r_state;
    t_state n_state;

    t_mode                       r_mode;
    logic signed [GAIN_BITS-1:0] r_dgain;
    logic signed [GAIN_BITS-1:0] r_ogain;
    logic [AW-1:0]               r_back;

    logic [AW-1:0] r_wr;
    logic          r_wrapped;
    logic          r_tap_ok;

    logic signed [SB-1:0] r_x    [NCH];
    logic signed [SB-1:0] r_t    [NCH];
    logic signed [SB-1:0] r_v    [NCH];
    logic signed [SB-1:0] r_res  [NCH];
    logic signed [PW-1:0] r_p_dg [NCH];
    logic signed [PW-1:0] r_p_xo [NCH];

    logic      r_o_valid;
    t_out_word r_o_data;

    logic          in_acc;
    logic          load_out;
    logic          mem_we;
    logic [AW:0]   tap_sum;
    logic [AW-1:0] tap_addr;
    logic [2*SB-1:0] mem_rdata;
    logic [2*SB-1:0] mem_wdata;

    logic signed [SB-1:0] tap     [NCH];
    logic signed [SB-1:0] sum_v   [NCH];
    logic signed [SB-1:0] sum_res [NCH];
    logic signed [SB-1:0] sum_st  [NCH];
    logic signed [SB-1:0] fin_res [NCH];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PASS;
            r_dgain <= '0;
            r_ogain <= OUTPUT_GAIN_RESET;
            r_back  <= f_len_mod(LEN_BITS'(1));
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODE:         r_mode  <= t_mode'(i_cfg_wdata[1:0]);
                CFG_DELAY_GAIN:   r_dgain <= i_cfg_wdata;
                CFG_OUTPUT_GAIN:  r_ogain <= i_cfg_wdata;
                CFG_DELAY_LENGTH: r_back  <= f_len_mod(i_cfg_wdata[LEN_BITS-1:0]);
                default:          r_mode  <= r_mode;
            endcase
        end
    end

    always_comb begin
        tap_sum = {1'b0, r_wr} + (AW+1)'(LINE_DEPTH) - {1'b0, r_back};
        if (tap_sum >= (AW+1)'(LINE_DEPTH)) begin
            tap_addr = AW'(tap_sum - (AW+1)'(LINE_DEPTH));
        end else begin
            tap_addr = tap_sum[AW-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_SUM;
            ST_SUM:  n_state = (r_mode == MODE_FEEDBACK) ? ST_GAIN : ST_DONE;
            ST_GAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_ready  = 1'b0;
        mem_we   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_ready  = 1'b1;
            ST_SUM:  mem_we   = (r_mode != MODE_PASS);
            ST_DONE: load_out = !r_o_valid || i_ready;
            default: o_ready  = 1'b0;
        endcase
    end

    assign in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wr      <= '0;
            r_wrapped <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                if (r_wr == AW'(LINE_DEPTH - 1)) begin
                    r_wr      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wr <= r_wr + 1'b1;
                end
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    scaf_ram #(
        .WIDTH (2 * SB),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr),
        .i_wdata (mem_wdata),
        .i_re    (in_acc),
        .i_raddr (tap_addr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        tap[0] = r_tap_ok ? mem_rdata[2*SB-1:SB] : '0;
        tap[1] = r_tap_ok ? mem_rdata[SB-1:0] : '0;
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            sum_v[c] = f_sat(SW'(f_trunc(r_p_dg[c])) + SW'(r_x[c]));
            case (r_mode)
                MODE_FEEDFWD: begin
                    sum_res[c] = f_sat(SW'(f_trunc(r_p_dg[c])) + SW'(f_trunc(r_p_xo[c])));
                    sum_st[c]  = r_x[c];
                end
                MODE_ALLPASS: begin
                    sum_res[c] = f_sat(SW'(f_trunc(r_p_xo[c])) + SW'(r_t[c]));
                    sum_st[c]  = sum_v[c];
                end
                default: begin
                    sum_res[c] = r_x[c];
                    sum_st[c]  = sum_v[c];
                end
            endcase
            fin_res[c] = (r_mode == MODE_FEEDBACK) ?
                         f_sat(SW'(f_trunc(r_p_xo[c]))) : r_res[c];
        end
    end

    assign mem_wdata = {sum_st[0], sum_st[1]};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x[0]   <= i_data.sample_a;
            r_x[1]   <= i_data.sample_b;
            r_tap_ok <= r_wrapped || (tap_addr < r_wr);
        end
        for (int c = 0; c < NCH; c++) begin
            case (r_state)
                ST_READ: begin
                    r_t[c]    <= tap[c];
                    r_p_dg[c] <= tap[c] * r_dgain;
                    r_p_xo[c] <= r_x[c] * r_ogain;
                end
                ST_SUM: begin
                    r_v[c]   <= sum_v[c];
                    r_res[c] <= sum_res[c];
                end
                ST_GAIN: r_p_xo[c] <= r_v[c] * r_ogain;
                default: r_t[c] <= r_t[c];
            endcase
        end
        if (load_out) begin
            r_o_data.result_a <= fin_res[0];
            r_o_data.result_b <= fin_res[1];
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

// File: hdl/scaf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaf_checker
// Port-level checks of the stereo comb and allpass filter, bound to the top.
// ----------------------------------------------------------------------------
module scaf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input scaf_pkg::t_out_word o_data
);

    import scaf_pkg::*;

    logic in_acc;

    assign in_acc = i_valid && o_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("Stalled result word changed or dropped.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result word valid right after reset.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("Input accepted while a word is in flight.");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
        else $error("Result word appeared too soon after acceptance.");

endmodule

bind stereo_comb_allpass_filter scaf_checker u_scaf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
